/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the keyboard macro sequencer.
// Files that assert include this header and expect signals named clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define KMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every rising edge, reset included.
`define KMS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

/* rtl/core/kms_pkg.sv */
// Package for the keyboard macro sequencer: word types and fixed codes.
// No dependencies; used by keyboard_macro_sequencer and its testbench.
`default_nettype none

package kms_pkg;

	// Command codes of an input word.
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_PRESS   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	// Key type that selects macro playback.
	localparam logic [7:0] MACRO_TYPE = 8'd32;

	// Byte address of the first record in the table.
	localparam int FIRST_RECORD = 2;

	typedef struct packed {
		logic [1:0] command;
		logic [9:0] table_address;
		logic [7:0] table_data;
		logic [7:0] key_code;
		logic [7:0] key_type;
	} item_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic [7:0] out_type;
		logic       is_press;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/keyboard_macro_sequencer.sv */
// Keyboard macro sequencer: macro table, record walker and action emitter.
// Depends on kms_pkg (word types, codes) and assert_macros.svh (assertions).
`default_nettype none

// The block holds a byte table of TABLE_BYTES entries, filled one byte per
// input word with the write command. Records start at byte 2; each record is
// a length byte followed by that many (key value, key type) pairs. A press or
// release word whose key type is 32 selects record number key_code: the block
// walks over the earlier records one at a time, then emits the pairs of the
// selected record (at most MAX_STEPS of them) as result words, in order for a
// press and in reverse order for a release, marking the final one with last.
// Key words give nothing while usb_present is low, for other key types, or
// for an empty record. One sequencer drives a single adder and a wrap unit
// that subtracts TABLE_BYTES once per cycle, and the table is a memory with
// one registered read port, so the block works on one word at a time and
// holds item_stall high until it has finished. A table write wraps its
// address by subtracting TABLE_BYTES until it lies in the table (never
// needed when TABLE_BYTES is at least 1024), then writes the byte. A key
// word reads and steps over each record skipped, reads the selected length,
// then fetches and emits each action, waiting while the result side stalls;
// wrapping adds a subtraction on an address step only when an address passes
// the table end. The table is not cleared at reset, so a byte must be
// written before a macro that reads it is played. The configuration port
// is always ready; usb_present resets to one.
module keyboard_macro_sequencer #(
	parameter int TABLE_BYTES = 1024,
	parameter int MAX_STEPS   = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	// Input words.
	input  wire               item_valid,
	output logic              item_stall,
	input  kms_pkg::item_t    item,
	// Result words.
	output logic              result_valid,
	input  wire               result_stall,
	output kms_pkg::result_t  result,
	// Configuration write channel: usb_present.
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_data
);

	// Table index width, width of an unwrapped address sum (the largest sum
	// is an address below TABLE_BYTES plus one plus twice a 255 length), and
	// width of an action count.
	localparam int AW = $clog2(TABLE_BYTES);
	localparam int SW = $clog2(TABLE_BYTES + 512);
	localparam int LW = $clog2(MAX_STEPS + 1);

	// Sequencer states.
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_WRAP     = 4'd1;
	localparam logic [3:0] S_WRITE    = 4'd2;
	localparam logic [3:0] S_SKIP_RD  = 4'd3;
	localparam logic [3:0] S_SKIP_ADD = 4'd4;
	localparam logic [3:0] S_LEN_RD   = 4'd5;
	localparam logic [3:0] S_LEN      = 4'd6;
	localparam logic [3:0] S_PAIR     = 4'd7;
	localparam logic [3:0] S_VAL_RD   = 4'd8;
	localparam logic [3:0] S_VAL      = 4'd9;
	localparam logic [3:0] S_TYP_RD   = 4'd10;
	localparam logic [3:0] S_TYP      = 4'd11;
	localparam logic [3:0] S_EMIT     = 4'd12;

	logic [3:0]       state_q;
	logic [3:0]       ret_q;     // state taken once the wrap unit has finished
	logic [SW-1:0]    sum_q;     // address being wrapped
	logic [AW-1:0]    ptr_q;     // wrapped table address, also the read address
	logic [AW-1:0]    base_q;    // length byte address of the selected record
	logic [7:0]       cnt_q;     // records still to skip
	logic [LW-1:0]    step_q;    // pair index of the action being fetched
	logic [LW-1:0]    rem_q;     // actions still to emit, this one included
	logic             press_q;
	logic [7:0]       data_q;    // byte to write
	logic [7:0]       val_q;     // key value of the action being fetched
	logic             usb_q;
	logic [7:0]       rd_q;      // registered read data
	kms_pkg::result_t res_q;
	logic             res_valid_q;

	// The macro table: one write and one registered read per cycle.
	logic [7:0]       mem_q [TABLE_BYTES];

	logic             item_acc;
	logic             res_acc;
	logic             key_hit;
	logic [SW-1:0]    add_a;
	logic [SW-1:0]    add_b;
	logic [SW-1:0]    sum_d;
	logic [LW-1:0]    len_d;
	logic             wrap_done;

	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign res_acc      = res_valid_q && !result_stall;
	assign cfg_ready    = 1'b1;

	// A key word plays a macro only for a press or release of the macro type
	// while a host is present.
	assign key_hit = usb_q && (item.key_type == kms_pkg::MACRO_TYPE) &&
		((item.command == kms_pkg::CMD_PRESS) || (item.command == kms_pkg::CMD_RELEASE));

	// Shared adder. Skipping a record adds one plus twice its length; a pair
	// address is the record base plus one plus twice the pair index; the key
	// type sits one byte after the key value.
	always_comb begin
		unique case (state_q)
			S_SKIP_ADD: begin
				add_a = SW'(ptr_q);
				add_b = SW'({rd_q, 1'b1});
			end
			S_PAIR: begin
				add_a = SW'(base_q);
				add_b = SW'({step_q, 1'b1});
			end
			default: begin
				add_a = SW'(ptr_q);
				add_b = SW'(1);
			end
		endcase
		sum_d = add_a + add_b;
	end

	// Lengths above MAX_STEPS play only the first MAX_STEPS pairs.
	assign len_d = (rd_q > 8'(MAX_STEPS)) ? LW'(MAX_STEPS) : LW'(rd_q);

	assign wrap_done = (sum_q < SW'(TABLE_BYTES));

	always_ff @(posedge clk) begin
		rd_q <= mem_q[ptr_q];
		if (state_q == S_WRITE) begin
			mem_q[ptr_q] <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			usb_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			ptr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						data_q  <= item.table_data;
						press_q <= (item.command == kms_pkg::CMD_PRESS);
						cnt_q   <= item.key_code;
						if (item.command == kms_pkg::CMD_WRITE) begin
							sum_q   <= SW'(item.table_address);
							ret_q   <= S_WRITE;
							state_q <= S_WRAP;
						end else if (key_hit) begin
							// The first record lies well inside the smallest table.
							ptr_q   <= AW'(kms_pkg::FIRST_RECORD);
							state_q <= (item.key_code == 8'd0) ? S_LEN_RD : S_SKIP_RD;
						end
					end
				end
				S_WRAP: begin
					if (wrap_done) begin
						ptr_q   <= sum_q[AW-1:0];
						state_q <= ret_q;
					end else begin
						sum_q <= sum_q - SW'(TABLE_BYTES);
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_SKIP_RD: begin
					state_q <= S_SKIP_ADD;
				end
				S_SKIP_ADD: begin
					sum_q   <= sum_d;
					cnt_q   <= cnt_q - 8'd1;
					ret_q   <= (cnt_q == 8'd1) ? S_LEN_RD : S_SKIP_RD;
					state_q <= S_WRAP;
				end
				S_LEN_RD: begin
					state_q <= S_LEN;
				end
				S_LEN: begin
					base_q <= ptr_q;
					rem_q  <= len_d;
					step_q <= press_q ? '0 : len_d - LW'(1);
					state_q <= (len_d == '0) ? S_IDLE : S_PAIR;
				end
				S_PAIR: begin
					sum_q   <= sum_d;
					ret_q   <= S_VAL_RD;
					state_q <= S_WRAP;
				end
				S_VAL_RD: begin
					state_q <= S_VAL;
				end
				S_VAL: begin
					val_q   <= rd_q;
					sum_q   <= sum_d;
					ret_q   <= S_TYP_RD;
					state_q <= S_WRAP;
				end
				S_TYP_RD: begin
					state_q <= S_TYP;
				end
				S_TYP: begin
					res_q.out_value <= val_q;
					res_q.out_type  <= rd_q;
					res_q.is_press  <= press_q;
					res_q.last      <= (rem_q == LW'(1));
					res_valid_q     <= 1'b1;
					state_q         <= S_EMIT;
				end
				S_EMIT: begin
					if (res_acc) begin
						res_valid_q <= 1'b0;
						if (rem_q == LW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							rem_q   <= rem_q - LW'(1);
							step_q  <= press_q ? step_q + LW'(1) : step_q - LW'(1);
							state_q <= S_PAIR;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "assert_macros.svh"

	// A result word is offered only while the sequencer waits to hand it over.
	`KMS_ASSERT_ALWAYS(a_result_in_emit, result_valid |-> (state_q == S_EMIT), "result outside emit")

	// The wrap unit always leaves a table address inside the table.
	`KMS_ASSERT(a_ptr_in_table, (SW'(ptr_q) < SW'(TABLE_BYTES)), "table address out of range")

	// While an action is in flight at least one action remains to be emitted.
	`KMS_ASSERT(a_rem_nonzero, (state_q == S_EMIT) |-> (rem_q != '0), "no actions left in emit")

	// Handing over the final action of a run frees the block for the next word.
	`KMS_ASSERT(a_last_ends_run, (res_acc && res_q.last) |=> (state_q == S_IDLE), "run did not end")

endmodule

`default_nettype wire

/* bench/tb_keyboard_macro_sequencer.sv */
// Testbench for keyboard_macro_sequencer: directed and randomised words,
// each result checked against a behavioural predictor of the macro table.
// Depends on kms_pkg and the keyboard_macro_sequencer RTL.
`timescale 1ns / 1ps

module tb_keyboard_macro_sequencer;

	localparam int TABLE_BYTES = 1024;
	localparam int MAX_STEPS   = 32;
	// Command 3 has no meaning; the block must drop it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Long enough for a key word that skips 255 records and plays 32 pairs
	// without stalls, so these quiet cycles cover a word still in progress
	// with no result.
	localparam int SETTLE_CYCLES = 1500;
	// Cycles with no word accepted on any channel before the run is abandoned.
	localparam int QUIET_LIMIT = 20000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	kms_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	kms_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             cfg_data;

	// Predictor state: the table as the block should hold it, which bytes have
	// been written, and the host presence register.
	logic [7:0] macro_bytes [TABLE_BYTES];
	bit         byte_written [TABLE_BYTES];
	bit         usb_on;

	// Key actions predicted but not yet seen on the result channel, oldest first.
	kms_pkg::result_t due_actions[$];

	int  mismatches   = 0;
	int  actions_seen = 0;
	int  words_sent   = 0;
	int  runs_played  = 0;
	int  quiet_cycles = 0;
	// While set, neither side inserts gaps or stalls.
	bit  calm;

	keyboard_macro_sequencer #(
		.TABLE_BYTES(TABLE_BYTES),
		.MAX_STEPS(MAX_STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int wrap(int a);
		return a % TABLE_BYTES;
	endfunction

	// Finds record number code by stepping over each earlier record, always by
	// its full stored length, even where that length exceeds MAX_STEPS.
	function automatic int record_start(logic [7:0] code);
		int pos;
		pos = kms_pkg::FIRST_RECORD;
		for (int i = 0; i < code; i++)
			pos = wrap(pos + 1 + 2 * macro_bytes[pos]);
		return pos;
	endfunction

	// True when playing record number code would read only bytes that have been
	// written. Key words that fail this are never sent with the macro type while
	// the host is present, since the table contents would be undefined.
	function automatic bit macro_playable(logic [7:0] code);
		int pos;
		int len;
		pos = kms_pkg::FIRST_RECORD;
		for (int i = 0; i <= code; i++) begin
			if (!byte_written[pos])
				return 1'b0;
			if (i < code)
				pos = wrap(pos + 1 + 2 * macro_bytes[pos]);
		end
		len = (macro_bytes[pos] > MAX_STEPS) ? MAX_STEPS : macro_bytes[pos];
		for (int k = 1; k <= 2 * len; k++)
			if (!byte_written[wrap(pos + k)])
				return 1'b0;
		return 1'b1;
	endfunction

	// Applies one accepted word to the predictor: a table write updates the
	// table, a macro key word queues the key actions it should produce.
	task automatic take_word(kms_pkg::item_t w);
		int               pos;
		int               len;
		int               pair;
		kms_pkg::result_t act;
		words_sent++;
		if (w.command == kms_pkg::CMD_WRITE) begin
			macro_bytes[w.table_address] = w.table_data;
			byte_written[w.table_address] = 1'b1;
		end else if (w.command != CMD_UNUSED && usb_on
				&& w.key_type == kms_pkg::MACRO_TYPE) begin
			pos = record_start(w.key_code);
			len = (macro_bytes[pos] > MAX_STEPS) ? MAX_STEPS : macro_bytes[pos];
			if (len != 0)
				runs_played++;
			for (int i = 0; i < len; i++) begin
				// A release plays the pairs back to front.
				pair = (w.command == kms_pkg::CMD_PRESS) ? i : len - 1 - i;
				act.out_value = macro_bytes[wrap(pos + 1 + 2 * pair)];
				act.out_type  = macro_bytes[wrap(pos + 2 + 2 * pair)];
				act.is_press  = (w.command == kms_pkg::CMD_PRESS);
				act.last      = (i == len - 1);
				due_actions.push_back(act);
			end
		end
	endtask

	// Word builders. Fields that the command does not use get random values so
	// that every bit of them toggles over the run.
	function automatic kms_pkg::item_t table_word(int addr, int data);
		kms_pkg::item_t w;
		w.command       = kms_pkg::CMD_WRITE;
		w.table_address = 10'(wrap(addr));
		w.table_data    = 8'(data);
		w.key_code      = 8'($urandom);
		w.key_type      = 8'($urandom);
		return w;
	endfunction

	function automatic kms_pkg::item_t key_word(logic [1:0] cmd, int code, int kind);
		kms_pkg::item_t w;
		w.command       = cmd;
		w.table_address = 10'($urandom);
		w.table_data    = 8'($urandom);
		w.key_code      = 8'(code);
		w.key_type      = 8'(kind);
		return w;
	endfunction

	task automatic report(string what, int got, int want);
		mismatches++;
		$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Sends one word after a random gap and returns at the edge where it was
	// accepted. With no gap, valid simply stays high for the next word.
	task automatic send_word(kms_pkg::item_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		take_word(w);
	endtask

	// Stops sending, waits for every predicted action, then lets the block
	// finish any word that gives no result.
	task automatic wait_drained(int settle);
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_actions.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Writes usb_present; only called while the block is idle.
	task automatic write_usb(bit v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		usb_on = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Four records close a loop through the end of the table:
	//   byte 2 (length 255) -> 513 (253) -> 1020 (empty) -> 1021 (two pairs) -> 2.
	// The last record reads its second pair across the wrap at 1024, and any
	// higher macro id walks round the loop again, so id 255 lands on it too.
	task automatic test_wrapping_chain();
		send_word(table_word(kms_pkg::FIRST_RECORD, 8'hFF));
		send_word(table_word(513, 253));
		send_word(table_word(1020, 8'h00));
		send_word(table_word(1021, 2));
		send_word(table_word(1022, 8'h04));
		send_word(table_word(1023, 8'h81));
		send_word(table_word(0, 8'hE1));
		send_word(table_word(1, 8'h3C));
		send_word(key_word(kms_pkg::CMD_PRESS, 3, kms_pkg::MACRO_TYPE));
		send_word(key_word(kms_pkg::CMD_RELEASE, 3, kms_pkg::MACRO_TYPE));
		send_word(key_word(kms_pkg::CMD_PRESS, 255, kms_pkg::MACRO_TYPE));
		send_word(key_word(kms_pkg::CMD_RELEASE, 255, kms_pkg::MACRO_TYPE));
		// The empty record must give nothing at all.
		send_word(key_word(kms_pkg::CMD_PRESS, 2, kms_pkg::MACRO_TYPE));
	endtask

	// Words that would otherwise play a macro but must be dropped: the unused command
	// and key types either side of the macro type.
	task automatic test_ignored_words();
		send_word(key_word(CMD_UNUSED, 3, kms_pkg::MACRO_TYPE));
		send_word(key_word(kms_pkg::CMD_PRESS, 3, kms_pkg::MACRO_TYPE - 1));
		send_word(key_word(kms_pkg::CMD_RELEASE, 3, 8'h00));
		send_word(key_word(kms_pkg::CMD_PRESS, 0, 8'hFF));
	endtask

	// With no host, key words are dropped but table writes still land; the
	// rewritten byte shows up once the host is back.
	task automatic test_usb_absent();
		wait_drained(SETTLE_CYCLES);
		write_usb(1'b0);
		send_word(key_word(kms_pkg::CMD_PRESS, 3, kms_pkg::MACRO_TYPE));
		send_word(key_word(kms_pkg::CMD_RELEASE, 255, kms_pkg::MACRO_TYPE));
		send_word(table_word(1022, 8'h7E));
		wait_drained(SETTLE_CYCLES);
		write_usb(1'b1);
		send_word(key_word(kms_pkg::CMD_PRESS, 3, kms_pkg::MACRO_TYPE));
	endtask

	// Bytes 3 to 66 get random content so that record 0 can play a full
	// MAX_STEPS pairs; its stored length then steps across the saturation point.
	// The record after it must be found past the full stored length.
	task automatic test_long_records();
		int len;
		int next_rec;
		for (int a = kms_pkg::FIRST_RECORD + 1; a <= kms_pkg::FIRST_RECORD + 2 * MAX_STEPS; a++)
			send_word(table_word(a, $urandom_range(0, 255)));
		for (int n = 0; n < 4; n++) begin
			case (n)
				0: len = MAX_STEPS;
				1: len = MAX_STEPS + 1;
				2: len = 255;
				default: len = $urandom_range(MAX_STEPS + 2, 254);
			endcase
			send_word(table_word(kms_pkg::FIRST_RECORD, len));
			send_word(key_word(kms_pkg::CMD_PRESS, 0, kms_pkg::MACRO_TYPE));
			send_word(key_word(kms_pkg::CMD_RELEASE, 0, kms_pkg::MACRO_TYPE));
		end
		next_rec = wrap(kms_pkg::FIRST_RECORD + 1 + 2 * len);
		send_word(table_word(next_rec, 1));
		send_word(table_word(next_rec + 1, $urandom_range(0, 255)));
		send_word(table_word(next_rec + 2, $urandom_range(0, 255)));
		send_word(key_word(kms_pkg::CMD_PRESS, 1, kms_pkg::MACRO_TYPE));
		send_word(key_word(kms_pkg::CMD_RELEASE, 1, kms_pkg::MACRO_TYPE));
	endtask

	// Four phases of random traffic, the second with no host and the last with no
	// idling. Most words rebuild a few short records from byte 2 and play them;
	// the rest are stray writes, dropped words and pauses until all is drained.
	task automatic test_random_traffic();
		int records;
		int cursor;
		int len;
		int pick;
		int code;
		int kind;
		int phase_end;
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained(SETTLE_CYCLES);
			write_usb(phase != 1);
			calm = (phase == 3);
			records = 0;
			phase_end = words_sent + 5;
			while (words_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 20) begin
					records = $urandom_range(1, 3);
					cursor = kms_pkg::FIRST_RECORD;
					for (int r = 0; r < records; r++) begin
						len = $urandom_range(0, 3);
						send_word(table_word(cursor, len));
						for (int k = 1; k <= 2 * len; k++)
							send_word(table_word(cursor + k, $urandom_range(0, 255)));
						cursor = wrap(cursor + 1 + 2 * len);
					end
				end else if (pick < 65) begin
					if (records != 0 && $urandom_range(0, 1))
						code = $urandom_range(0, records);
					else
						code = $urandom_range(0, 255);
					for (int t = 0; t < 8 && usb_on && !macro_playable(8'(code)); t++)
						code = $urandom_range(0, 7);
					// Still unsafe to play: send it as an ordinary key instead.
					kind = (!usb_on || macro_playable(8'(code))) ? kms_pkg::MACRO_TYPE
						: $urandom_range(0, 31);
					send_word(key_word($urandom_range(0, 1) ? kms_pkg::CMD_PRESS
						: kms_pkg::CMD_RELEASE, code, kind));
				end else if (pick < 77) begin
					send_word(table_word($urandom_range(0, TABLE_BYTES - 1),
						$urandom_range(0, 255)));
				end else if (pick < 94) begin
					kind = $urandom_range(0, 254);
					if (kind >= kms_pkg::MACRO_TYPE)
						kind++;
					if ($urandom_range(0, 2) == 0)
						send_word(key_word(CMD_UNUSED, $urandom_range(0, 255),
							$urandom_range(0, 255)));
					else
						send_word(key_word($urandom_range(0, 1) ? kms_pkg::CMD_PRESS
							: kms_pkg::CMD_RELEASE, $urandom_range(0, 255), kind));
				end else begin
					// Hold off until the block has delivered everything owed.
					wait_drained(0);
				end
			end
		end
		calm = 1'b0;
	endtask

	// Result side: draws a stall length after each accepted word and compares
	// every accepted word with the oldest predicted action.
	initial begin
		int               hold;
		kms_pkg::result_t want;
		result_stall <= 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				actions_seen++;
				if (due_actions.size() == 0) begin
					report("result word with nothing expected", result, 0);
				end else begin
					want = due_actions.pop_front();
					if (result.out_value !== want.out_value)
						report("out_value", result.out_value, want.out_value);
					if (result.out_type !== want.out_type)
						report("out_type", result.out_type, want.out_type);
					if (result.is_press !== want.is_press)
						report("is_press", result.is_press, want.is_press);
					if (result.last !== want.last)
						report("last", result.last, want.last);
				end
				hold = calm ? 0 : $urandom_range(0, 19);
				result_stall <= (hold != 0);
			end else if (hold != 0) begin
				hold--;
				if (hold == 0)
					result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a run that accepts nothing for this long has hung.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** keyboard_macro_sequencer: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= 1'b0;
		usb_on = 1'b1;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wrapping_chain();
		test_ignored_words();
		test_usb_absent();
		test_long_records();
		test_random_traffic();
		wait_drained(SETTLE_CYCLES);

		$display("Sent %0d words: %0d macro runs gave %0d key actions, across wrapped,",
			words_sent, runs_played, actions_seen);
		$display("empty and saturated records, dropped words and host presence both ways.");
		if (mismatches == 0)
			$display("** keyboard_macro_sequencer: PASSED **");
		else
			$display("** keyboard_macro_sequencer: FAILED **");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/kms_pkg.sv
rtl/core/keyboard_macro_sequencer.sv
bench/tb_keyboard_macro_sequencer.sv
